// ===== design/itf_pkg.sv =====
`default_nettype none

package itf_pkg;

   // Sizes of the number and of the text
   localparam int VALUE_BITS     = 64;
   localparam int MAX_WIDTH      = 63;
   localparam int OPCODE_BITS    = 3;
   localparam int WIDTH_BITS     = 6;
   localparam int CHAR_BITS      = 7;

   // One digit slot per octal digit covers every base
   localparam int NUM_DIGITS     = (VALUE_BITS + 2) / 3;
   localparam int DIGIT_VEC      = 4 * NUM_DIGITS;
   localparam int DIGIT_IDX_BITS = $clog2(NUM_DIGITS);
   localparam int CNT_BITS       = $clog2(VALUE_BITS + 1);
   localparam int PAD_BITS       = 8;
   localparam int PC_BITS        = 4;

   // Conversion codes
   localparam logic [OPCODE_BITS-1:0] OPC_S32_DEC = 3'd0;
   localparam logic [OPCODE_BITS-1:0] OPC_S64_DEC = 3'd1;
   localparam logic [OPCODE_BITS-1:0] OPC_U_DEC   = 3'd2;
   localparam logic [OPCODE_BITS-1:0] OPC_HEX_LO  = 3'd3;
   localparam logic [OPCODE_BITS-1:0] OPC_HEX_UP  = 3'd4;
   localparam logic [OPCODE_BITS-1:0] OPC_OCTAL   = 3'd5;
   localparam logic [OPCODE_BITS-1:0] OPC_POINTER = 3'd6;

   // Fixed characters
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_X     = 7'h78;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 7'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_A  = 7'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_UP_A  = 7'h41;

   // Branch conditions of the microprogram
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_CONV_MORE,
      COND_TOP_ZERO,
      COND_NOT_PTR,
      COND_SPACE_PAD,
      COND_NEG,
      COND_ZERO_PAD,
      COND_IDX_NZ
   } cond_type;

   // Datapath operation of a step
   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_DABBLE,
      STEP_SCAN,
      STEP_CALC_PAD,
      STEP_PAD,
      STEP_DIGIT
   } step_type;

   // Character source of a step
   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_X,
      SEL_SPACE,
      SEL_MINUS,
      SEL_DIGIT
   } sel_type;

   // When a step sends a character
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_ALWAYS,
      EMIT_IF_TAKEN,
      EMIT_IF_NOT
   } emit_type;

   // One microprogram word
   typedef struct packed {
      cond_type            cond;
      logic [PC_BITS-1:0]  tgt;
      logic [PC_BITS-1:0]  nxt;
      step_type            step;
      sel_type             sel;
      emit_type            emit;
   } ctrl_word_type;

   // Sequencer to datapath
   typedef struct packed {
      logic     load;
      step_type step;
      sel_type  sel;
      logic     fire;
      logic     taken;
   } seq_ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic conv_more;
      logic top_zero;
      logic ptr;
      logic space_pad;
      logic zero_pad;
      logic neg;
      logic idx_nz;
   } dp_status_type;

   // Digit glyph table
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d,
                                                       input logic       upper);
      logic [CHAR_BITS-1:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end else if (upper) begin
         c = CHAR_UP_A + CHAR_BITS'(d - 4'd10);
      end else begin
         c = CHAR_LO_A + CHAR_BITS'(d - 4'd10);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/itf_sequencer.sv =====
`default_nettype none

module itf_sequencer (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  itf_pkg::dp_status_type status,
   output logic                  busy,
   output itf_pkg::seq_ctrl_type ctrl
);
   import itf_pkg::*;

   localparam logic [PC_BITS-1:0] PC_IDLE   = 4'd0;
   localparam logic [PC_BITS-1:0] PC_CONV   = 4'd1;
   localparam logic [PC_BITS-1:0] PC_SCAN   = 4'd2;
   localparam logic [PC_BITS-1:0] PC_CALC   = 4'd3;
   localparam logic [PC_BITS-1:0] PC_PFX0   = 4'd4;
   localparam logic [PC_BITS-1:0] PC_PFX1   = 4'd5;
   localparam logic [PC_BITS-1:0] PC_SPACES = 4'd6;
   localparam logic [PC_BITS-1:0] PC_SIGN   = 4'd7;
   localparam logic [PC_BITS-1:0] PC_ZEROS  = 4'd8;
   localparam logic [PC_BITS-1:0] PC_DIGITS = 4'd9;

   logic [PC_BITS-1:0] pc_ff;
   logic [PC_BITS-1:0] pc_in;
   ctrl_word_type      word;
   logic               taken;

   // Microprogram store: condition, target, fall-through, operation, character
   function automatic ctrl_word_type program_word(input logic [PC_BITS-1:0] pc);
      ctrl_word_type w;
      case (pc)
         PC_IDLE:   w = '{COND_NO_START,  PC_IDLE,   PC_CONV,
                          STEP_NONE,     SEL_ZERO,  EMIT_NONE};
         PC_CONV:   w = '{COND_CONV_MORE, PC_CONV,   PC_SCAN,
                          STEP_DABBLE,   SEL_ZERO,  EMIT_NONE};
         PC_SCAN:   w = '{COND_TOP_ZERO,  PC_SCAN,   PC_CALC,
                          STEP_SCAN,     SEL_ZERO,  EMIT_NONE};
         PC_CALC:   w = '{COND_NEVER,     PC_CALC,   PC_PFX0,
                          STEP_CALC_PAD, SEL_ZERO,  EMIT_NONE};
         PC_PFX0:   w = '{COND_NOT_PTR,   PC_SPACES, PC_PFX1,
                          STEP_NONE,     SEL_ZERO,  EMIT_IF_NOT};
         PC_PFX1:   w = '{COND_NEVER,     PC_PFX1,   PC_SPACES,
                          STEP_NONE,     SEL_X,     EMIT_ALWAYS};
         PC_SPACES: w = '{COND_SPACE_PAD, PC_SPACES, PC_SIGN,
                          STEP_PAD,      SEL_SPACE, EMIT_IF_TAKEN};
         PC_SIGN:   w = '{COND_NEG,       PC_ZEROS,  PC_ZEROS,
                          STEP_NONE,     SEL_MINUS, EMIT_IF_TAKEN};
         PC_ZEROS:  w = '{COND_ZERO_PAD,  PC_ZEROS,  PC_DIGITS,
                          STEP_PAD,      SEL_ZERO,  EMIT_IF_TAKEN};
         PC_DIGITS: w = '{COND_IDX_NZ,    PC_DIGITS, PC_IDLE,
                          STEP_DIGIT,    SEL_DIGIT, EMIT_ALWAYS};
         default:   w = '{COND_ALWAYS,    PC_IDLE,   PC_IDLE,
                          STEP_NONE,     SEL_ZERO,  EMIT_NONE};
      endcase
      return w;
   endfunction

   assign word = program_word(pc_ff);

   // Evaluate the branch condition
   always_comb begin
      case (word.cond)
         COND_NEVER:     taken = 1'b0;
         COND_ALWAYS:    taken = 1'b1;
         COND_NO_START:  taken = !start;
         COND_CONV_MORE: taken = status.conv_more;
         COND_TOP_ZERO:  taken = status.top_zero;
         COND_NOT_PTR:   taken = !status.ptr;
         COND_SPACE_PAD: taken = status.space_pad;
         COND_NEG:       taken = status.neg;
         COND_ZERO_PAD:  taken = status.zero_pad;
         COND_IDX_NZ:    taken = status.idx_nz;
         default:        taken = 1'b0;
      endcase
   end

   assign pc_in = taken ? word.tgt : word.nxt;
   assign busy  = (pc_ff != PC_IDLE);

   // Drive the datapath
   always_comb begin
      ctrl.load  = (pc_ff == PC_IDLE) && start;
      ctrl.step  = word.step;
      ctrl.sel   = word.sel;
      ctrl.taken = taken;
      case (word.emit)
         EMIT_NONE:     ctrl.fire = 1'b0;
         EMIT_ALWAYS:   ctrl.fire = 1'b1;
         EMIT_IF_TAKEN: ctrl.fire = taken;
         EMIT_IF_NOT:   ctrl.fire = !taken;
         default:       ctrl.fire = 1'b0;
      endcase
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/itf_datapath.sv =====
`default_nettype none

module itf_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  itf_pkg::seq_ctrl_type                ctrl,
   input  wire [itf_pkg::OPCODE_BITS-1:0]       req_opcode,
   input  wire [63:0]                           req_value,
   input  wire [itf_pkg::WIDTH_BITS-1:0]        req_field_width,
   input  wire                                  req_zero_fill,
   output itf_pkg::dp_status_type               status,
   output logic                                 rsp_strobe,
   output logic [itf_pkg::CHAR_BITS-1:0]        rsp_character,
   output logic                                 rsp_last
);
   import itf_pkg::*;

   // Request registers
   logic                      dec_ff, dec_in;
   logic                      upper_ff, upper_in;
   logic                      ptr_ff, ptr_in;
   logic                      neg_ff, neg_in;
   logic                      zero_ff, zero_in;
   logic [WIDTH_BITS-1:0]     width_ff, width_in;

   // Conversion registers
   logic [VALUE_BITS-1:0]     shreg_ff, shreg_in;
   logic [DIGIT_VEC-1:0]      dig_ff, dig_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [DIGIT_IDX_BITS-1:0] idx_ff, idx_in;
   logic [PAD_BITS-1:0]       pad_ff, pad_in;

   // Result registers
   logic                      strobe_ff, strobe_in;
   logic [CHAR_BITS-1:0]      char_ff, char_in;
   logic                      last_ff, last_in;

   logic [VALUE_BITS-1:0]     val;
   logic [VALUE_BITS-1:0]     mag;
   logic [31:0]               word32;
   logic [31:0]               mag32;
   logic                      oct;
   logic [DIGIT_VEC-1:0]      ext;
   logic [DIGIT_VEC-1:0]      sliced;
   logic [DIGIT_VEC-1:0]      adj;
   logic [3:0]                cur_dig;
   logic                      pad_pos;

   assign val    = req_value[VALUE_BITS-1:0];
   assign word32 = req_value[31:0];

   // Negate the 32-bit word at its own width
   assign mag32  = word32[31] ? (~word32 + 32'd1) : word32;

   // Decode the request and take the magnitude
   always_comb begin
      dec_in   = 1'b1;
      upper_in = 1'b0;
      ptr_in   = 1'b0;
      neg_in   = 1'b0;
      oct      = 1'b0;
      mag      = val;
      case (req_opcode)
         OPC_S32_DEC: begin
            neg_in = word32[31];
            mag    = VALUE_BITS'(mag32);
         end
         OPC_S64_DEC: begin
            neg_in = val[VALUE_BITS-1];
            mag    = val[VALUE_BITS-1] ? (~val + VALUE_BITS'(1)) : val;
         end
         OPC_HEX_LO: begin
            dec_in = 1'b0;
         end
         OPC_HEX_UP: begin
            dec_in   = 1'b0;
            upper_in = 1'b1;
         end
         OPC_OCTAL: begin
            dec_in = 1'b0;
            oct    = 1'b1;
         end
         OPC_POINTER: begin
            dec_in = 1'b0;
            ptr_in = 1'b1;
         end
         default: begin
            dec_in = 1'b1;
         end
      endcase
   end

   // Split hex and octal values straight into digit slots
   assign ext = DIGIT_VEC'(mag);
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         sliced[4*i +: 4] = oct ? {1'b0, ext[3*i +: 3]} : ext[4*i +: 4];
      end
   end

   // Add three to every BCD digit of five or more
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (dig_ff[4*i +: 4] >= 4'd5) ? (dig_ff[4*i +: 4] + 4'd3)
                                                    : dig_ff[4*i +: 4];
      end
   end

   assign cur_dig = dig_ff[{idx_ff, 2'b00} +: 4];
   assign pad_pos = !pad_ff[PAD_BITS-1] && (pad_ff != '0);

   // Report to the sequencer
   always_comb begin
      status.conv_more = dec_ff && (cnt_ff != CNT_BITS'(1));
      status.top_zero  = (cur_dig == 4'd0) && (idx_ff != '0);
      status.ptr       = ptr_ff;
      status.space_pad = !zero_ff && pad_pos;
      status.zero_pad  = zero_ff && pad_pos;
      status.neg       = neg_ff;
      status.idx_nz    = (idx_ff != '0);
   end

   // Next values of the working registers
   always_comb begin
      width_in = width_ff;
      zero_in  = zero_ff;
      shreg_in = shreg_ff;
      dig_in   = dig_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      pad_in   = pad_ff;
      if (ctrl.load) begin
         width_in = (req_field_width > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH)
                                                               : req_field_width;
         zero_in  = req_zero_fill;
         shreg_in = mag;
         dig_in   = dec_in ? '0 : sliced;
         cnt_in   = CNT_BITS'(VALUE_BITS);
         idx_in   = DIGIT_IDX_BITS'(NUM_DIGITS - 1);
      end else begin
         case (ctrl.step)
            STEP_DABBLE: begin
               if (dec_ff) begin
                  dig_in   = {adj[DIGIT_VEC-2:0], shreg_ff[VALUE_BITS-1]};
                  shreg_in = {shreg_ff[VALUE_BITS-2:0], 1'b0};
                  cnt_in   = cnt_ff - CNT_BITS'(1);
               end
            end
            STEP_SCAN: begin
               if (ctrl.taken) begin
                  idx_in = idx_ff - DIGIT_IDX_BITS'(1);
               end
            end
            STEP_CALC_PAD: begin
               pad_in = PAD_BITS'(width_ff) - (ptr_ff ? PAD_BITS'(2) : PAD_BITS'(0))
                        - PAD_BITS'(idx_ff) - PAD_BITS'(1) - PAD_BITS'(neg_ff);
            end
            STEP_PAD: begin
               if (ctrl.fire) begin
                  pad_in = pad_ff - PAD_BITS'(1);
               end
            end
            STEP_DIGIT: begin
               if (idx_ff != '0) begin
                  idx_in = idx_ff - DIGIT_IDX_BITS'(1);
               end
            end
            default: begin
               idx_in = idx_ff;
            end
         endcase
      end
   end

   // Pick the outgoing character
   always_comb begin
      strobe_in = ctrl.fire;
      last_in   = (ctrl.sel == SEL_DIGIT) && (idx_ff == '0);
      case (ctrl.sel)
         SEL_ZERO:  char_in = CHAR_ZERO;
         SEL_X:     char_in = CHAR_X;
         SEL_SPACE: char_in = CHAR_SPACE;
         SEL_MINUS: char_in = CHAR_MINUS;
         SEL_DIGIT: char_in = digit_char(cur_dig, upper_ff);
         default:   char_in = CHAR_ZERO;
      endcase
   end

   // Hold the request flags until the next transfer in
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         dec_ff   <= dec_in;
         upper_ff <= upper_in;
         ptr_ff   <= ptr_in;
         neg_ff   <= neg_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      width_ff <= width_in;
      zero_ff  <= zero_in;
      shreg_ff <= shreg_in;
      dig_ff   <= dig_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      pad_ff   <= pad_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ===== design/integer_to_text_formatter_unit.sv =====
`default_nettype none

// Channel   Ports                                                    Transfer
// request   start, busy, req_opcode, req_value, req_field_width,     start && !busy
//           req_zero_fill
// result    rsp_strobe, rsp_character, rsp_last                      rsp_strobe
//
// One request passes through an accept step, a binary to BCD conversion for
// decimal codes only, a leading-zero scan, the pad arithmetic, then the
// characters (1 to 63) plus steps that send nothing (prefix test, loop exits,
// sign test); each character appears from a register in the cycle after its
// step.
// Reset returns the sequencer to its idle step and clears the result strobe.
// The receiver cannot stall: every character is shown for exactly one cycle.
module integer_to_text_formatter_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire [itf_pkg::OPCODE_BITS-1:0]      req_opcode,
   input  wire [63:0]                          req_value,
   input  wire [itf_pkg::WIDTH_BITS-1:0]       req_field_width,
   input  wire                                 req_zero_fill,
   output logic                                rsp_strobe,
   output logic [itf_pkg::CHAR_BITS-1:0]       rsp_character,
   output logic                                rsp_last
);
   import itf_pkg::*;

   seq_ctrl_type  ctrl;
   dp_status_type status;

   // Microprogram sequencer
   itf_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   // Conversion and character datapath
   itf_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .req_field_width (req_field_width),
      .req_zero_fill   (req_zero_fill),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_character   (rsp_character),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
